>>> rtl/cbm_pkg.sv
// Package for the cartridge bank mapper: beat structs, controller/datapath
// command and status structs, state enum and sizing constants.
// No dependencies.
package cbm_pkg;

    localparam int SLOT_COUNT = 3;
    localparam int SLOT_W     = 2;
    localparam int OFFSET_W   = 14;
    localparam int BANK_W     = 8;
    localparam int ROM_ADDR_W = BANK_W + OFFSET_W;
    localparam int STEP_W     = 3;

    localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_beat;

    typedef struct packed {
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  open_bus;
    } t_out_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WB
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_out;    // capture read result into output register
        logic div_start;   // latch bank write operands
        logic div_step;    // one remainder bit
        logic bank_write;  // commit remainder to bank register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_write;
        logic write_hit;   // write at offset 0 of a mapped slot, ROM present
    } t_dp_sts;

endpackage

>>> rtl/cbm_datapath.sv
// Datapath of the cartridge bank mapper: page count register, bank
// registers, bit-serial remainder unit and output register. Uses cbm_pkg.
module cbm_datapath
    import cbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  t_in_beat  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output t_out_beat o_out_data
);

    logic [7:0]        r_page_count;
    logic [BANK_W-1:0] r_bank [SLOT_COUNT];
    logic [7:0]        r_rem;
    logic [7:0]        r_quo;
    logic [SLOT_W-1:0] r_div_slot;
    t_out_beat         r_out;

    logic [SLOT_W-1:0]   in_slot;
    logic [OFFSET_W-1:0] in_offset;
    logic                slot_mapped;
    logic [8:0]          shifted;
    logic [8:0]          divisor;
    logic [8:0]          diff;
    logic [7:0]          n_rem;

    assign in_slot     = i_in_data.address[15:14];
    assign in_offset   = i_in_data.address[OFFSET_W-1:0];
    assign slot_mapped = (in_slot != 2'd3);

    assign o_sts.is_write  = (i_in_data.func == FUNC_WRITE);
    assign o_sts.write_hit = (in_offset == '0) && slot_mapped && (r_page_count != 8'd0);

    // restoring remainder step
    assign shifted = {r_rem, r_quo[7]};
    assign divisor = {1'b0, r_page_count};
    assign diff    = shifted - divisor;
    assign n_rem   = (shifted >= divisor) ? diff[7:0] : shifted[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= 8'd0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_bank[i] <= BANK_W'(i);
            end
        end else begin
            if (i_cfg_we) begin
                r_page_count <= i_cfg_wdata;
            end
            if (i_cmd.bank_write) begin
                r_bank[r_div_slot] <= r_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem      <= 8'd0;
            r_quo      <= i_in_data.write_data;
            r_div_slot <= in_slot;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (!slot_mapped || (r_page_count == 8'd0)) begin
                r_out.rom_address <= '0;
                r_out.open_bus    <= 1'b1;
            end else begin
                r_out.rom_address <= {r_bank[in_slot], in_offset};
                r_out.open_bus    <= 1'b0;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

>>> rtl/cbm_ctrl.sv
// Controller of the cartridge bank mapper: handshakes, output valid and
// sequencing of the bank-write remainder. Uses cbm_pkg.
module cbm_ctrl
    import cbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              in_ready;
    logic              in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        in_ready    = 1'b0;
        in_acc      = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                in_ready = !r_out_valid || i_out_ready;
                in_acc   = in_ready && i_in_valid;
                if (in_acc) begin
                    if (!i_sts.is_write) begin
                        o_cmd.load_out = 1'b1;
                        n_out_valid    = 1'b1;
                    end else if (i_sts.write_hit) begin
                        o_cmd.div_start = 1'b1;
                        n_step          = '0;
                        n_state         = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.bank_write = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/cartridge_bank_mapper.sv
// Top level of the cartridge bank mapper: joins controller and datapath.
// Depends on cbm_pkg, cbm_ctrl and cbm_datapath.
//
//  channel   | signals                              | beat
//  ----------+--------------------------------------+---------------------------
//  input     | i_in_valid / o_in_ready / i_in_data  | func, address, write_data
//  output    | o_out_valid / i_out_ready / o_out_data| rom_address, open_bus
//  config    | i_cfg_we / i_cfg_wdata               | rom_page_count
//
// A read lands its result in the output register on the accepting edge, and
// the next beat is taken as soon as that register is free or being emptied
// in the same cycle. A bank write that hits runs a latch, 8 steps of the
// bit-serial remainder unit and a commit. Other writes give no beat.
// Synchronous active-low reset clears the page count to zero and the slot
// banks to pages 0, 1, 2. A stalled output holds its beat and blocks new
// input until taken.
module cartridge_bank_mapper
    import cbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_beat   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_data,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    cbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cbm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for cartridge_bank_mapper: directed and random CPU bus
// beats, predicted in the bench and checked beat by beat at the output.
// Depends on cbm_pkg and the cartridge_bank_mapper RTL.
module tb_top;
    import cbm_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either side
    localparam int SETTLE      = 16;    // lets a bank write hit finish
    localparam int HOLD_AT     = 300;   // output beat that starts the long stall
    localparam int HOLD_LEN    = 400;
    localparam int RAND_PER_PH = 220;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_beat    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_beat   out_data;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    // bench copy of the mapper state
    logic [7:0]  page_count = '0;
    logic [7:0]  bank_sel [SLOT_COUNT] = '{8'd0, 8'd1, 8'd2};

    t_in_beat    pending_beats [$];
    t_out_beat   expected_reads [$];
    int unsigned beats_queued = 0;
    int unsigned beats_taken  = 0;
    int unsigned beats_out    = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int          drv_calm     = 0;
    int          mon_calm     = 0;

    cartridge_bank_mapper uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Bus access as the mapper sees it. Returns 1 and the mapped result for a
    // read; a write only updates the bank registers and returns 0.
    function automatic bit map_access(input t_in_beat b, output t_out_beat r);
        logic [1:0]  slot;
        logic [13:0] ofs;
        slot = b.address[15:14];
        ofs  = b.address[13:0];
        r    = '0;
        if (b.func == FUNC_WRITE) begin
            // only offset 0 of slots 0..2 with ROM present selects a bank
            if (ofs == '0 && slot < SLOT_COUNT && page_count != '0) begin
                bank_sel[slot] = b.write_data % page_count;
            end
            return 1'b0;
        end
        if (page_count == '0 || slot >= SLOT_COUNT) begin
            r.open_bus = 1'b1;      // no ROM, or slot 3: open bus, address 0
        end else begin
            r.rom_address = {bank_sel[slot], ofs};  // bank * 16K + offset
        end
        return 1'b1;
    endfunction

    // Wait before the next beat, drawn at random, with runs of back-to-back beats.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(16, 48);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic t_in_beat make_access();
        t_in_beat    b;
        int unsigned pick;
        logic [1:0]  slot;
        logic [13:0] ofs;
        pick = $urandom_range(0, 99);
        slot = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       ofs = '0;
            1:       ofs = 14'h3FFF;
            default: ofs = 14'($urandom());
        endcase
        b.write_data = 8'($urandom());
        if (pick < 45) begin
            b.func    = FUNC_READ;
            b.address = ($urandom_range(0, 1) == 0) ? {slot, ofs} : 16'($urandom());
        end else if (pick < 75) begin
            // bank select at a slot base, data biased to the modulo edges
            b.func    = FUNC_WRITE;
            b.address = {slot, 14'h0};
            case ($urandom_range(0, 5))
                0:       b.write_data = 8'h00;
                1:       b.write_data = 8'hFF;
                2:       b.write_data = page_count - 8'd1;
                3:       b.write_data = page_count;
                default: b.write_data = 8'($urandom());
            endcase
        end else if (pick < 90) begin
            b.func    = FUNC_WRITE;
            b.address = 16'($urandom());
        end else begin
            // near miss: just off a slot base
            b.func    = FUNC_WRITE;
            b.address = {slot, ($urandom_range(0, 1) == 0) ? 14'h0001 : 14'h3FFF};
        end
        return b;
    endfunction

    task automatic queue_beat(input logic func, input logic [15:0] addr,
                              input logic [7:0] data);
        t_in_beat b;
        b.func       = func;
        b.address    = addr;
        b.write_data = data;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // Block until every queued beat is taken and every read has come back,
    // then let a bank write still in flight finish.
    task automatic drain();
        while (beats_taken != beats_queued || expected_reads.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_page_count(input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        page_count = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic note_error(input string msg);
        if (mismatches < 10) begin
            $display("%s", msg);
        end
        mismatches++;
    endtask

    // Driver: one beat at a time from pending_beats, random gap after each.
    always @(posedge clk) begin : drive_in
        bit       v;
        bit       is_read;
        t_out_beat r;
        int       gap_left;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            v = in_valid;
            if (in_valid && in_ready) begin
                is_read = map_access(in_data, r);
                if (is_read) begin
                    expected_reads.push_back(r);
                end
                beats_taken++;
                v        = 1'b0;
                gap_left = draw_wait(drv_calm);
            end
            if (!v) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_beats.size() != 0) begin
                    in_data <= pending_beats.pop_front();
                    v = 1'b1;
                end
            end
            in_valid <= v;
        end
    end

    // Monitor: checks each output beat and paces ready. Once, the receiver
    // holds off for a long stall so the block backs up into its input.
    always @(posedge clk) begin : watch_out
        bit        r;
        t_out_beat want;
        int        stall_left;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            r = out_ready;
            if (out_ready && out_valid) begin
                beats_out++;
                if (expected_reads.size() == 0) begin
                    note_error($sformatf("unexpected beat: rom_address=%h open_bus=%b",
                                         out_data.rom_address, out_data.open_bus));
                end else begin
                    want = expected_reads.pop_front();
                    if (out_data.rom_address !== want.rom_address) begin
                        note_error($sformatf("rom_address: expected %h, got %h",
                                             want.rom_address, out_data.rom_address));
                    end
                    if (out_data.open_bus !== want.open_bus) begin
                        note_error($sformatf("open_bus: expected %b, got %b",
                                             want.open_bus, out_data.open_bus));
                    end
                end
                r          = 1'b0;
                stall_left = (beats_out == HOLD_AT) ? HOLD_LEN : draw_wait(mon_calm);
            end
            if (!r) begin
                if (stall_left > 0) begin
                    stall_left--;
                end else begin
                    r = 1'b1;
                end
            end
            out_ready <= r;
        end
    end

    // Watchdog: a run with no beat on either side for too long is hung.
    always @(posedge clk) begin : watchdog
        if ((in_valid && in_ready) || (out_ready && out_valid)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] rand_counts [9];
        rand_counts = '{8'd2, 8'd255, 8'd1, 8'($urandom_range(3, 254)), 8'd0,
                        8'd128, 8'($urandom_range(1, 254)), 8'd7, 8'd254};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no ROM after reset: every read is open bus, bank writes are dropped
        queue_beat(FUNC_READ,  16'h0000, 8'h00);
        queue_beat(FUNC_READ,  16'h7FFF, 8'hFF);
        queue_beat(FUNC_WRITE, 16'h4000, 8'h05);
        queue_beat(FUNC_WRITE, 16'h0000, 8'hFF);
        queue_beat(FUNC_READ,  16'hFFFF, 8'h00);
        drain();

        // one page: reset banks 1 and 2 still point past the end
        set_page_count(8'd1);
        queue_beat(FUNC_READ,  16'h4000, 8'h00);
        queue_beat(FUNC_READ,  16'hBFFF, 8'h00);
        queue_beat(FUNC_READ,  16'h0000, 8'h00);
        queue_beat(FUNC_READ,  16'hC000, 8'h00);
        queue_beat(FUNC_WRITE, 16'h4000, 8'hFF);
        queue_beat(FUNC_READ,  16'h7FFF, 8'h00);
        drain();

        // full 255 pages: modulo edges, slot 3 write, off-base writes
        set_page_count(8'd255);
        queue_beat(FUNC_WRITE, 16'h0000, 8'hFF);
        queue_beat(FUNC_WRITE, 16'h8000, 8'hFE);
        queue_beat(FUNC_WRITE, 16'h4000, 8'h80);
        queue_beat(FUNC_WRITE, 16'hC000, 8'h11);
        queue_beat(FUNC_WRITE, 16'h4001, 8'h22);
        queue_beat(FUNC_WRITE, 16'hBFFF, 8'h33);
        queue_beat(FUNC_READ,  16'h0000, 8'h00);
        queue_beat(FUNC_READ,  16'h3FFF, 8'h00);
        queue_beat(FUNC_READ,  16'h4000, 8'h00);
        queue_beat(FUNC_READ,  16'h8000, 8'h00);
        queue_beat(FUNC_READ,  16'hBFFF, 8'h00);
        queue_beat(FUNC_READ,  16'hC000, 8'h00);
        queue_beat(FUNC_READ,  16'hFFFF, 8'h00);
        drain();

        foreach (rand_counts[p]) begin
            set_page_count(rand_counts[p]);
            repeat (RAND_PER_PH) pending_beats.push_back(make_access());
            beats_queued += RAND_PER_PH;
            drain();
        end

        if (expected_reads.size() != 0) begin
            note_error($sformatf("%0d reads never came back", expected_reads.size()));
        end
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
